### hw/rtl/otb_pkg.sv
// ----------------------------------------------------------------------------
// otb_pkg
// shared constants and types of the otsu threshold binarizer
// ----------------------------------------------------------------------------
package otb_pkg;

    localparam int OTB_COUNT_BITS  = 24;
    localparam int OTB_BINS        = 256;
    localparam int OTB_PIX_BITS    = 8;
    localparam int OTB_QUEUE_DEPTH = 4;
    localparam int OTB_DIGIT_BITS  = 8;

    typedef enum logic [1:0] {
        ITEM_COUNT,
        ITEM_COUNT_LAST,
        ITEM_CLASSIFY
    } item_class_t;

    typedef struct packed {
        item_class_t             cls;
        logic [OTB_PIX_BITS-1:0] pixel;
    } queue_item_t;

    typedef struct packed {
        logic        valid;
        queue_item_t item;
    } queue_head_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HIST_WR,
        ST_SUM_RD,
        ST_SUM_ACC,
        ST_WALK_RD,
        ST_WALK_UPD,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_DONE
    } back_state_t;

    typedef enum logic [2:0] {
        MS_A,
        MS_B,
        MS_SQ,
        MS_DEN,
        MS_LHS,
        MS_RHS
    } mul_step_t;

endpackage

### hw/rtl/otb_front.sv
// ----------------------------------------------------------------------------
// otb_front
// accepts input beats, tags each with its kind of work and queues it
// ----------------------------------------------------------------------------
module otb_front
    import otb_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    kind,
    input  logic [OTB_PIX_BITS-1:0] pixel,
    input  logic                    last,
    input  logic                    pop_q,
    output queue_head_t             head
);

    localparam int PW = $clog2(OTB_QUEUE_DEPTH);
    localparam int NW = $clog2(OTB_QUEUE_DEPTH + 1);

    queue_item_t       entry_reg [OTB_QUEUE_DEPTH];
    logic [PW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]     count_reg, count_next;
    queue_item_t       in_item;
    logic              do_push;
    logic              do_pop;

    always_comb
    begin
        in_item.pixel = pixel;
        if (kind)
            in_item.cls = ITEM_CLASSIFY;
        else if (last)
            in_item.cls = ITEM_COUNT_LAST;
        else
            in_item.cls = ITEM_COUNT;
    end

    assign full    = (count_reg == NW'(OTB_QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop_q && (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PW'(OTB_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PW'(OTB_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= in_item;
    end

    assign head.valid = (count_reg != '0);
    assign head.item  = entry_reg[rd_ptr_reg];

endmodule

### hw/rtl/otb_mul.sv
// ----------------------------------------------------------------------------
// otb_mul
// shift-add multiplier, one digit of the second operand per cycle
// ----------------------------------------------------------------------------
module otb_mul
    import otb_pkg::*;
#(
    parameter int AW = 176,
    parameter int BW = 56
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [AW-1:0] a,
    input  logic [BW-1:0] b,
    output logic [AW-1:0] product,
    output logic          done
);

    localparam int DB = OTB_DIGIT_BITS;

    logic [AW-1:0] a_reg;
    logic [BW-1:0] b_reg;
    logic [AW-1:0] acc_reg;
    logic          busy_reg;
    logic [AW-1:0] partial;

    assign partial = a_reg * AW'(b_reg[DB-1:0]);
    assign done    = busy_reg && (b_reg == '0);
    assign product = acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else if (start)
            busy_reg <= 1'b1;
        else if (done)
            busy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (busy_reg && (b_reg != '0))
        begin
            acc_reg <= acc_reg + partial;
            a_reg   <= a_reg << DB;
            b_reg   <= b_reg >> DB;
        end
    end

endmodule

### hw/rtl/otb_back.sv
// ----------------------------------------------------------------------------
// otb_back
// histogram store, otsu search sequencer and result register
// ----------------------------------------------------------------------------
module otb_back
    import otb_pkg::*;
#(
    parameter int COUNT_BITS = OTB_COUNT_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  queue_head_t             head,
    output logic                    pop_q,
    output logic                    empty,
    input  logic                    pop,
    output logic                    result_kind,
    output logic [OTB_PIX_BITS-1:0] threshold,
    output logic                    black_white
);

    localparam int CW = COUNT_BITS;
    localparam int SW = CW + OTB_PIX_BITS;
    localparam int NW = 2 * CW + OTB_PIX_BITS;
    localparam int QW = 2 * NW;
    localparam int DW = 2 * CW;
    localparam int BW = OTB_DIGIT_BITS * ((NW + OTB_DIGIT_BITS - 1) / OTB_DIGIT_BITS);
    localparam int AW = QW + BW;
    localparam int LW = QW + DW;
    localparam int XW = $clog2(OTB_BINS);

    back_state_t   state_reg, state_next;
    mul_step_t     step_reg, step_next;
    logic [XW-1:0] t_reg, t_next;
    logic [CW-1:0] total_reg, total_next;
    logic [OTB_PIX_BITS-1:0] held_reg, held_next;
    logic [OTB_BINS-1:0] valid_reg, valid_next;

    logic [CW-1:0] mem [OTB_BINS];
    logic [CW-1:0] rd_data_reg;
    logic          rd_valid_reg;
    logic [XW-1:0] rd_addr;
    logic          mem_we;

    logic [SW-1:0] sum_reg, sum_next;
    logic [SW-1:0] sum_b_reg, sum_b_next;
    logic [CW-1:0] wb_reg, wb_next;
    logic [CW-1:0] wf_reg, wf_next;
    logic [NW-1:0] a_val_reg, a_val_next;
    logic [NW-1:0] num_reg, num_next;
    logic [QW-1:0] sq_reg, sq_next;
    logic [DW-1:0] den_reg, den_next;
    logic [LW-1:0] lhs_reg, lhs_next;
    logic [QW-1:0] best_n_reg, best_n_next;
    logic [DW-1:0] best_d_reg, best_d_next;
    logic [XW-1:0] thr_reg, thr_next;

    logic          res_valid_reg;
    logic          res_kind_reg;
    logic [OTB_PIX_BITS-1:0] res_thr_reg;
    logic          res_bw_reg;
    logic          res_load;
    logic          res_kind_in;
    logic [OTB_PIX_BITS-1:0] res_thr_in;
    logic          res_bw_in;
    logic          slot_free;

    logic          mul_start;
    logic [AW-1:0] mul_a;
    logic [BW-1:0] mul_b;
    logic [AW-1:0] mul_p;
    logic          mul_done;

    logic [CW-1:0] cnt;
    logic [SW-1:0] tprod;
    logic [CW-1:0] wb_sum;
    logic [CW-1:0] wf_diff;
    logic [NW-1:0] b_val;
    logic          saturated;
    logic          last_bin;

    assign slot_free = !res_valid_reg || pop;
    assign saturated = (total_reg == '1);
    assign last_bin  = (t_reg == XW'(OTB_BINS - 1));
    assign cnt       = rd_valid_reg ? rd_data_reg : '0;
    assign tprod     = SW'(t_reg) * SW'(cnt);
    assign wb_sum    = wb_reg + cnt;
    assign wf_diff   = total_reg - wb_sum;
    assign b_val     = NW'(mul_p);

    otb_mul #(
        .AW (AW),
        .BW (BW)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .product (mul_p),
        .done    (mul_done)
    );

    // operand select, narrower factor on the digit side
    always_comb
    begin
        case (step_reg)
            MS_A:
            begin
                mul_a = AW'(sum_b_reg);
                mul_b = BW'(total_reg);
            end
            MS_B:
            begin
                mul_a = AW'(sum_reg);
                mul_b = BW'(wb_reg);
            end
            MS_SQ:
            begin
                mul_a = AW'(num_reg);
                mul_b = BW'(num_reg);
            end
            MS_DEN:
            begin
                mul_a = AW'(wb_reg);
                mul_b = BW'(wf_reg);
            end
            MS_LHS:
            begin
                mul_a = AW'(sq_reg);
                mul_b = BW'(best_d_reg);
            end
            MS_RHS:
            begin
                mul_a = AW'(best_n_reg);
                mul_b = BW'(den_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (head.valid)
                begin
                    if (head.item.cls inside {ITEM_COUNT, ITEM_COUNT_LAST})
                    begin
                        if (!saturated)
                            state_next = ST_HIST_WR;
                        else if (head.item.cls == ITEM_COUNT_LAST)
                            state_next = ST_SUM_RD;
                    end
                end
            end
            ST_HIST_WR:
            begin
                if (head.item.cls == ITEM_COUNT_LAST)
                    state_next = ST_SUM_RD;
                else
                    state_next = ST_IDLE;
            end
            ST_SUM_RD:
                state_next = ST_SUM_ACC;
            ST_SUM_ACC:
                state_next = last_bin ? ST_WALK_RD : ST_SUM_RD;
            ST_WALK_RD:
                state_next = ST_WALK_UPD;
            ST_WALK_UPD:
            begin
                if (wb_sum == '0)
                    state_next = last_bin ? ST_DONE : ST_WALK_RD;
                else if (wf_diff == '0)
                    state_next = ST_DONE;
                else
                    state_next = ST_MUL_GO;
            end
            ST_MUL_GO:
                state_next = ST_MUL_WAIT;
            ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    if (step_reg == MS_RHS)
                        state_next = last_bin ? ST_DONE : ST_WALK_RD;
                    else
                        state_next = ST_MUL_GO;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        step_next   = step_reg;
        t_next      = t_reg;
        total_next  = total_reg;
        held_next   = held_reg;
        valid_next  = valid_reg;
        sum_next    = sum_reg;
        sum_b_next  = sum_b_reg;
        wb_next     = wb_reg;
        wf_next     = wf_reg;
        a_val_next  = a_val_reg;
        num_next    = num_reg;
        sq_next     = sq_reg;
        den_next    = den_reg;
        lhs_next    = lhs_reg;
        best_n_next = best_n_reg;
        best_d_next = best_d_reg;
        thr_next    = thr_reg;
        rd_addr     = t_reg;
        mem_we      = 1'b0;
        pop_q       = 1'b0;
        mul_start   = 1'b0;
        res_load    = 1'b0;
        res_kind_in = 1'b0;
        res_thr_in  = held_reg;
        res_bw_in   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                rd_addr = head.item.pixel;
                t_next  = '0;
                sum_next = '0;
                if (head.valid)
                begin
                    case (head.item.cls)
                        ITEM_CLASSIFY:
                        begin
                            if (slot_free)
                            begin
                                res_load    = 1'b1;
                                res_kind_in = 1'b1;
                                res_bw_in   = (head.item.pixel <= held_reg);
                                pop_q       = 1'b1;
                            end
                        end
                        ITEM_COUNT:
                            pop_q = saturated;
                        ITEM_COUNT_LAST:
                            ;
                        default:
                            pop_q = 1'b1;
                    endcase
                end
            end
            ST_HIST_WR:
            begin
                mem_we     = 1'b1;
                valid_next[head.item.pixel] = 1'b1;
                total_next = total_reg + 1'b1;
                if (head.item.cls != ITEM_COUNT_LAST)
                    pop_q = 1'b1;
            end
            ST_SUM_ACC:
            begin
                sum_next = sum_reg + tprod;
                if (last_bin)
                begin
                    t_next      = '0;
                    wb_next     = '0;
                    sum_b_next  = '0;
                    best_n_next = '0;
                    best_d_next = DW'(1);
                    thr_next    = '0;
                end
                else
                    t_next = t_reg + 1'b1;
            end
            ST_WALK_UPD:
            begin
                wb_next = wb_sum;
                if (wb_sum == '0)
                    t_next = t_reg + 1'b1;
                else if (wf_diff != '0)
                begin
                    wf_next    = wf_diff;
                    sum_b_next = sum_b_reg + tprod;
                    step_next  = MS_A;
                end
            end
            ST_MUL_GO:
                mul_start = 1'b1;
            ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    case (step_reg)
                        MS_A:
                        begin
                            a_val_next = NW'(mul_p);
                            step_next  = MS_B;
                        end
                        MS_B:
                        begin
                            num_next  = (a_val_reg >= b_val) ? a_val_reg - b_val
                                                             : b_val - a_val_reg;
                            step_next = MS_SQ;
                        end
                        MS_SQ:
                        begin
                            sq_next   = QW'(mul_p);
                            step_next = MS_DEN;
                        end
                        MS_DEN:
                        begin
                            den_next  = DW'(mul_p);
                            step_next = MS_LHS;
                        end
                        MS_LHS:
                        begin
                            lhs_next  = LW'(mul_p);
                            step_next = MS_RHS;
                        end
                        MS_RHS:
                        begin
                            // strictly larger keeps the first best t
                            if (lhs_reg > LW'(mul_p))
                            begin
                                best_n_next = sq_reg;
                                best_d_next = den_reg;
                                thr_next    = t_reg;
                            end
                            t_next = t_reg + 1'b1;
                        end
                        default:
                            step_next = MS_A;
                    endcase
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    held_next   = thr_reg;
                    res_load    = 1'b1;
                    res_thr_in  = thr_reg;
                    valid_next  = '0;
                    total_next  = '0;
                    pop_q       = 1'b1;
                end
            end
            default:
                ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= MS_A;
            t_reg         <= '0;
            total_reg     <= '0;
            held_reg      <= '0;
            valid_reg     <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            t_reg     <= t_next;
            total_reg <= total_next;
            held_reg  <= held_next;
            valid_reg <= valid_next;
            if (res_load)
                res_valid_reg <= 1'b1;
            else if (pop)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg    <= sum_next;
        sum_b_reg  <= sum_b_next;
        wb_reg     <= wb_next;
        wf_reg     <= wf_next;
        a_val_reg  <= a_val_next;
        num_reg    <= num_next;
        sq_reg     <= sq_next;
        den_reg    <= den_next;
        lhs_reg    <= lhs_next;
        best_n_reg <= best_n_next;
        best_d_reg <= best_d_next;
        thr_reg    <= thr_next;
        if (res_load)
        begin
            res_kind_reg <= res_kind_in;
            res_thr_reg  <= res_thr_in;
            res_bw_reg   <= res_bw_in;
        end
    end

    // histogram store, read data registered
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[head.item.pixel] <= cnt + 1'b1;
        rd_data_reg  <= mem[rd_addr];
        rd_valid_reg <= valid_reg[rd_addr] && !(mem_we && valid_next == '0);
    end

    assign empty       = !res_valid_reg;
    assign result_kind = res_kind_reg;
    assign threshold   = res_thr_reg;
    assign black_white = res_bw_reg;

endmodule

### hw/rtl/otsu_threshold_binarizer.sv
// ----------------------------------------------------------------------------
// otsu_threshold_binarizer
// two-pass otsu binarizer: histogram pass, threshold search, classify pass
// ----------------------------------------------------------------------------
// Input beats enter a four-entry queue and are worked off one at a time by
// the back end. A classify beat is handled in ST_IDLE and a histogram beat in
// ST_IDLE and ST_HIST_WR (read and write of its bin in the store). The beat
// marked last starts the threshold search: ST_SUM_RD and ST_SUM_ACC for each
// of the 256 bins to form the weighted sum, then ST_WALK_RD and ST_WALK_UPD
// for each bin without background weight, and for each other bin those two
// states plus six products on one shared shift-add multiplier. Bins are
// marked by valid flops, so clearing the histogram after a search is instant
// and reset needs no sweep. The report of a search and each classification
// sit in an output register until popped.
// ----------------------------------------------------------------------------
module otsu_threshold_binarizer
    import otb_pkg::*;
#(
    parameter int COUNT_BITS = OTB_COUNT_BITS
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    kind,
    input  logic [OTB_PIX_BITS-1:0] pixel,
    input  logic                    last,
    output logic                    empty,
    input  logic                    pop,
    output logic                    result_kind,
    output logic [OTB_PIX_BITS-1:0] threshold,
    output logic                    black_white
);

    queue_head_t head;
    logic        pop_q;

    otb_front u_front (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .kind  (kind),
        .pixel (pixel),
        .last  (last),
        .pop_q (pop_q),
        .head  (head)
    );

    otb_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .pop_q       (pop_q),
        .empty       (empty),
        .pop         (pop),
        .result_kind (result_kind),
        .threshold   (threshold),
        .black_white (black_white)
    );

    a_pop_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop_q |-> head.valid)
        else $error("back end retired a beat from an empty queue");

    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> head.valid)
        else $error("queue full without a head beat");

    a_report_bw_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result_kind) |-> !black_white)
        else $error("threshold report with black_white set");

endmodule
